[design/mcc_pkg.sv]
// Shared types and constants for the multichannel 1-D convolution block.
// No dependencies; every other design file imports this package.
package mcc_pkg;

    localparam int VALUE_W   = 16;
    localparam int RESULT_W  = 26;
    localparam int FRAC_BITS = 12;
    localparam int POS_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd2;

    localparam logic MODE_WEIGHT = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic signed [VALUE_W-1:0]  value;
        logic [3:0]                 weight_out_channel;
        logic [3:0]                 weight_in_channel;
        logic [2:0]                 weight_tap;
        logic                       last_sample;
    } t_in_req;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result;
        logic [3:0]                 out_channel;
        logic [POS_W-1:0]           position;
        logic                       last_result;
    } t_out_req;

    // Control tag that travels with one multiply-accumulate term.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic use_term;
    } t_term_ctl;

endpackage

[design/multichannel_conv1d_same_pad.sv]
// Multichannel 1-D convolution with zero same padding, streamed request by request.
// A weight request, or a sample that leaves its position open, is taken while idle. A sample
// that completes a position holds the input unready while its up to nout*(lag+1) results
// are formed in turn, each from nin*ksz terms on the single weight-store read port and
// MAC (stalled while the output register still holds an unaccepted request). Reset is synchronous, active
// low: counters, state and valids clear; weight store and window data stay undefined.
module multichannel_conv1d_same_pad #(
    parameter int MAX_IN_CHANNELS  = 16,
    parameter int MAX_OUT_CHANNELS = 16,
    parameter int MAX_KERNEL       = 7,
    parameter int MAX_POSITIONS    = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mcc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mcc_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mcc_pkg::t_in_req                  i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mcc_pkg::t_out_req                 o_out_req
);
    import mcc_pkg::*;

    localparam int ICW   = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
    localparam int OCW   = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int NCW   = $clog2(MAX_IN_CHANNELS + 1);
    localparam int NOW   = $clog2(MAX_OUT_CHANNELS + 1);
    localparam int KW    = $clog2(MAX_KERNEL + 1);
    localparam int DW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int PW    = $clog2(MAX_POSITIONS);
    localparam int DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = 2 * VALUE_W + $clog2(MAX_IN_CHANNELS * MAX_KERNEL + 1);
    localparam int ACC_W = (SUM_W > RESULT_W + FRAC_BITS) ? SUM_W : RESULT_W + FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_EMIT,
        S_FINISH
    } t_state;

    t_state               r_state;
    logic [CFG_DAT_W-1:0] r_cfg_in;
    logic [CFG_DAT_W-1:0] r_cfg_out;
    logic [2:0]           r_cfg_k;
    logic [ICW-1:0]       r_ch_cnt;
    logic [PW-1:0]        r_pos;
    logic [KW-1:0]        r_filled;
    logic                 r_last;
    logic [KW-1:0]        r_back;
    logic [OCW-1:0]       r_oc;
    logic [KW-1:0]        r_k;
    logic [ICW-1:0]       r_ic;
    logic                 r_out_valid;
    t_out_req             r_out_req;

    // Effective register values, clamped to the supported ranges.
    logic [NCW-1:0] nin;
    logic [NOW-1:0] nout;
    logic [KW-1:0]  ksz;
    logic [KW-1:0]  pad;
    logic [KW-1:0]  lag;

    always_comb begin
        if (r_cfg_in == '0) begin
            nin = NCW'(1);
        end else if (int'(r_cfg_in) > MAX_IN_CHANNELS) begin
            nin = NCW'(MAX_IN_CHANNELS);
        end else begin
            nin = NCW'(r_cfg_in);
        end
        if (r_cfg_out == '0) begin
            nout = NOW'(1);
        end else if (int'(r_cfg_out) > MAX_OUT_CHANNELS) begin
            nout = NOW'(MAX_OUT_CHANNELS);
        end else begin
            nout = NOW'(r_cfg_out);
        end
        if (r_cfg_k == '0) begin
            ksz = KW'(1);
        end else if (int'(r_cfg_k) > MAX_KERNEL) begin
            ksz = KW'(MAX_KERNEL);
        end else begin
            ksz = KW'(r_cfg_k);
        end
        pad = ksz >> 1;
        lag = ksz - KW'(1) - pad;
    end

    logic accept;
    logic is_sample;
    logic cfg_hit;
    logic [ICW-1:0] ch_sel;
    logic complete;
    logic [KW-1:0] n_filled;
    logic [KW-1:0] back_start;
    logic has_out;

    assign accept    = i_in_valid & o_in_ready;
    assign is_sample = (i_in_req.mode == MODE_SAMPLE);
    // A write to a known register index restarts the sequence.
    assign cfg_hit   = i_cfg_we & ((i_cfg_index == CFG_IN_CHANNELS)
                                 | (i_cfg_index == CFG_OUT_CHANNELS)
                                 | (i_cfg_index == CFG_KERNEL_SIZE));

    always_comb begin
        // Hold the channel at the last one if the count ran past it.
        ch_sel   = (NCW'(r_ch_cnt) >= nin) ? ICW'(nin - NCW'(1)) : r_ch_cnt;
        complete = ({1'b0, NCW'(ch_sel)} + (NCW + 1)'(1) >= {1'b0, nin})
                   | i_in_req.last_sample;
        n_filled = (r_filled < KW'(MAX_KERNEL)) ? r_filled + KW'(1) : r_filled;
        if (i_in_req.last_sample) begin
            back_start = (lag < n_filled) ? lag : n_filled - KW'(1);
        end else begin
            back_start = lag;
        end
        has_out = i_in_req.last_sample | (lag < n_filled);
    end

    // Weight write address and range check.
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;

    assign w_wr_en = accept & !is_sample
                   & (int'(i_in_req.weight_out_channel) < MAX_OUT_CHANNELS)
                   & (int'(i_in_req.weight_in_channel) < MAX_IN_CHANNELS)
                   & (int'(i_in_req.weight_tap) < MAX_KERNEL);
    assign w_wr_addr = AW'((int'(i_in_req.weight_out_channel) * MAX_IN_CHANNELS
                          + int'(i_in_req.weight_in_channel)) * MAX_KERNEL
                          + int'(i_in_req.weight_tap));

    // Window: cell 0 builds the current position, cell d holds the one d positions back.
    logic [MAX_IN_CHANNELS-1:0][VALUE_W-1:0] cell_data [MAX_KERNEL];
    logic [MAX_IN_CHANNELS-1:0]              cell_vld  [MAX_KERNEL];
    logic [VALUE_W-1:0]                      cell_rd   [MAX_KERNEL];
    logic                                    shift;

    // A restart also shifts, so a half-built position never leaks into the next sequence.
    assign shift = (r_state == S_FINISH) | cfg_hit;

    for (genvar g = 0; g < MAX_KERNEL; g++) begin : g_cell
        if (g == 0) begin : g_head
            mcc_cell #(
                .MAX_IN_CHANNELS(MAX_IN_CHANNELS),
                .ICW(ICW)
            ) u_cell (
                .i_clk(i_clk),
                .i_rst_n(i_rst_n),
                .i_shift(shift),
                .i_prev_data('0),
                .i_prev_vld('0),
                .i_wr_en(accept & is_sample),
                .i_wr_ch(ch_sel),
                .i_wr_data(i_in_req.value),
                .i_rd_ch(r_ic),
                .o_data(cell_data[g]),
                .o_vld(cell_vld[g]),
                .o_rd(cell_rd[g])
            );
        end else begin : g_tail
            mcc_cell #(
                .MAX_IN_CHANNELS(MAX_IN_CHANNELS),
                .ICW(ICW)
            ) u_cell (
                .i_clk(i_clk),
                .i_rst_n(i_rst_n),
                .i_shift(shift),
                .i_prev_data(cell_data[g-1]),
                .i_prev_vld(cell_vld[g-1]),
                .i_wr_en(1'b0),
                .i_wr_ch(ch_sel),
                .i_wr_data(i_in_req.value),
                .i_rd_ch(r_ic),
                .o_data(cell_data[g]),
                .o_vld(cell_vld[g]),
                .o_rd(cell_rd[g])
            );
        end
    end

    // Term issue: tap k of output position (current - back) reads input position
    // (current - back - pad + k); taps before the sequence start or past it are dropped.
    logic [KW-1:0]         bp;
    logic [KW-1:0]         tap_dist;
    logic                  use_term;
    logic                  last_term;
    logic signed [VALUE_W-1:0] x_sel;
    t_term_ctl             term_ctl;
    logic [AW-1:0]         rd_addr;
    logic                  mac_done;
    logic signed [ACC_W-1:0] mac_acc;

    always_comb begin
        bp        = r_back + pad;
        tap_dist  = bp - r_k;
        use_term  = (bp >= r_k) && (tap_dist < r_filled);
        x_sel     = use_term ? cell_rd[tap_dist[DW-1:0]] : '0;
        last_term = (r_k == ksz - KW'(1)) && (NCW'(r_ic) == nin - NCW'(1));
        term_ctl.valid    = (r_state == S_ISSUE);
        term_ctl.first    = (r_k == '0) && (r_ic == '0);
        term_ctl.last     = last_term;
        term_ctl.use_term = use_term;
        rd_addr = AW'((int'(r_oc) * MAX_IN_CHANNELS + int'(r_ic)) * MAX_KERNEL + int'(r_k));
    end

    mcc_mac #(
        .DEPTH(DEPTH),
        .AW(AW),
        .ACC_W(ACC_W)
    ) u_mac (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_wr_en(w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(i_in_req.value),
        .i_ctl(term_ctl),
        .i_rd_addr(rd_addr),
        .i_x(x_sel),
        .o_done(mac_done),
        .o_acc(mac_acc)
    );

    // Reported position wraps modulo the position range.
    logic [PW:0]  pos_diff;
    logic         final_res;
    logic [PW-1:0] n_pos;

    always_comb begin
        if ({1'b0, r_pos} >= (PW + 1)'(r_back)) begin
            pos_diff = {1'b0, r_pos} - (PW + 1)'(r_back);
        end else begin
            pos_diff = {1'b0, r_pos} + (PW + 1)'(MAX_POSITIONS) - (PW + 1)'(r_back);
        end
        final_res = (NOW'(r_oc) == nout - NOW'(1))
                    && (r_back == (r_last ? KW'(0) : lag));
        n_pos = (int'(r_pos) == MAX_POSITIONS - 1) ? '0 : r_pos + PW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_in    <= CFG_DAT_W'(1);
            r_cfg_out   <= CFG_DAT_W'(1);
            r_cfg_k     <= 3'd3;
            r_ch_cnt    <= '0;
            r_pos       <= '0;
            r_filled    <= '0;
            r_last      <= 1'b0;
            r_back      <= '0;
            r_oc        <= '0;
            r_k         <= '0;
            r_ic        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // A write to a known register abandons the current sequence.
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IN_CHANNELS:  r_cfg_in  <= i_cfg_data;
                    CFG_OUT_CHANNELS: r_cfg_out <= i_cfg_data;
                    CFG_KERNEL_SIZE:  r_cfg_k   <= i_cfg_data[2:0];
                    default: ;
                endcase
                if (cfg_hit) begin
                    r_ch_cnt <= '0;
                    r_pos    <= '0;
                    r_filled <= '0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && is_sample) begin
                        if (!complete) begin
                            r_ch_cnt <= ch_sel + ICW'(1);
                        end else begin
                            r_ch_cnt <= '0;
                            r_filled <= n_filled;
                            r_last   <= i_in_req.last_sample;
                            r_back   <= back_start;
                            r_oc     <= '0;
                            r_k      <= '0;
                            r_ic     <= '0;
                            r_state  <= has_out ? S_ISSUE : S_FINISH;
                        end
                    end
                end
                S_ISSUE: begin
                    // Advance channel first, then tap.
                    if (NCW'(r_ic) == nin - NCW'(1)) begin
                        r_ic <= '0;
                        r_k  <= r_k + KW'(1);
                    end else begin
                        r_ic <= r_ic + ICW'(1);
                    end
                    if (last_term) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (mac_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // Load the output register once its previous request is gone.
                    if (!r_out_valid) begin
                        r_out_valid           <= 1'b1;
                        r_out_req.result      <= mac_acc[RESULT_W+FRAC_BITS-1:FRAC_BITS];
                        r_out_req.out_channel <= 4'(r_oc);
                        r_out_req.position    <= POS_W'(pos_diff);
                        r_out_req.last_result <= final_res;
                        r_k  <= '0;
                        r_ic <= '0;
                        if (NOW'(r_oc) == nout - NOW'(1)) begin
                            r_oc <= '0;
                            if (final_res) begin
                                r_state <= S_FINISH;
                            end else begin
                                r_back  <= r_back - KW'(1);
                                r_state <= S_ISSUE;
                            end
                        end else begin
                            r_oc    <= r_oc + OCW'(1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_FINISH: begin
                    // The window shifts here; a sequence end also drops the counters.
                    if (r_last) begin
                        r_pos    <= '0;
                        r_filled <= '0;
                    end else begin
                        r_pos <= n_pos;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

[design/mcc_cell.sv]
// One window cell: all input channels of one sequence position.
// Depends on mcc_pkg; chained in the top level as a shift line.
module mcc_cell #(
    parameter int MAX_IN_CHANNELS = 16,
    parameter int ICW = 4
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_shift,
    input  logic [MAX_IN_CHANNELS-1:0][mcc_pkg::VALUE_W-1:0] i_prev_data,
    input  logic [MAX_IN_CHANNELS-1:0]                      i_prev_vld,
    input  logic                                            i_wr_en,
    input  logic [ICW-1:0]                                  i_wr_ch,
    input  logic [mcc_pkg::VALUE_W-1:0]                     i_wr_data,
    input  logic [ICW-1:0]                                  i_rd_ch,
    output logic [MAX_IN_CHANNELS-1:0][mcc_pkg::VALUE_W-1:0] o_data,
    output logic [MAX_IN_CHANNELS-1:0]                      o_vld,
    output logic [mcc_pkg::VALUE_W-1:0]                     o_rd
);
    import mcc_pkg::*;

    logic [MAX_IN_CHANNELS-1:0][VALUE_W-1:0] r_data;
    logic [MAX_IN_CHANNELS-1:0]              r_vld;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_prev_data;
        end else if (i_wr_en) begin
            r_data[i_wr_ch] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_shift) begin
            r_vld <= i_prev_vld;
        end else if (i_wr_en) begin
            r_vld[i_wr_ch] <= 1'b1;
        end
    end

    // Channels never written in this position read as zero.
    assign o_data = r_data;
    assign o_vld  = r_vld;
    assign o_rd   = r_vld[i_rd_ch] ? r_data[i_rd_ch] : '0;

endmodule

[design/mcc_mac.sv]
// Weight store and three-stage multiply-accumulate pipeline.
// Depends on mcc_pkg (term control tag, value width).
module mcc_mac #(
    parameter int DEPTH = 1792,
    parameter int AW    = 11,
    parameter int ACC_W = 40
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [AW-1:0]                       i_wr_addr,
    input  logic signed [mcc_pkg::VALUE_W-1:0]  i_wr_data,
    input  mcc_pkg::t_term_ctl                  i_ctl,
    input  logic [AW-1:0]                       i_rd_addr,
    input  logic signed [mcc_pkg::VALUE_W-1:0]  i_x,
    output logic                                o_done,
    output logic signed [ACC_W-1:0]             o_acc
);
    import mcc_pkg::*;

    localparam int PROD_W = 2 * VALUE_W;

    logic signed [VALUE_W-1:0] r_wmem [DEPTH];
    logic signed [VALUE_W-1:0] r_w;
    logic signed [VALUE_W-1:0] r_x;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    t_term_ctl                 r_c1;
    t_term_ctl                 r_c2;
    logic                      r_done;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_wmem[i_wr_addr] <= i_wr_data;
        end
        r_w <= r_wmem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_x <= i_x;
        // Skipped taps contribute zero; the weight read there may be unwritten.
        r_prod <= r_c1.use_term ? PROD_W'(r_x * r_w) : '0;
        if (r_c2.valid) begin
            r_acc <= (r_c2.first ? '0 : r_acc) + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1   <= '0;
            r_c2   <= '0;
            r_done <= 1'b0;
        end else begin
            r_c1   <= i_ctl;
            r_c2   <= r_c1;
            r_done <= r_c2.valid & r_c2.last;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

[tb/sv/mcc_checker.sv]
// Result checker for the multichannel 1-D convolution: predicts every result
// from the observed configuration writes and requests. Depends on mcc_pkg.
module mcc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mcc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  mcc_pkg::t_in_req              i_in_req,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  mcc_pkg::t_out_req             i_out_req,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mcc_pkg::*;

    localparam int NIN_MAX  = 16;
    localparam int NOUT_MAX = 16;
    localparam int KMAX     = 7;

    logic signed [VALUE_W-1:0] coef_mem [0:NOUT_MAX*NIN_MAX*KMAX-1];
    logic signed [VALUE_W-1:0] window   [0:KMAX*NIN_MAX-1];
    logic [POS_W-1:0]          pos_cnt;
    int                        ch_cnt, head, filled;
    logic [4:0]                reg_in, reg_out;
    logic [2:0]                reg_k;
    t_out_req                  sums_q [$];

    function automatic int clamp_cnt(int v, int m);
        if (v == 0) return 1;
        return (v > m) ? m : v;
    endfunction

    function automatic void clear_seq();
        pos_cnt = '0;
        ch_cnt  = 0;
        head    = 0;
        filled  = 0;
    endfunction

    // Floor-shifted sum for one output channel, 'back' positions behind the head.
    function automatic logic [RESULT_W-1:0] conv_sum(int oc, int back, int nin, int ksz,
                                                     int pad);
        longint acc;
        int     rel, slot;
        acc = 0;
        for (int k = 0; k < ksz; k++) begin
            rel = k - pad - back;
            if (rel > 0 || -rel >= filled) continue;
            slot = (head + KMAX + rel) % KMAX;
            for (int ic = 0; ic < nin; ic++)
                acc += longint'(window[slot*NIN_MAX+ic]) *
                       longint'(coef_mem[(oc*NIN_MAX+ic)*KMAX+k]);
        end
        acc = acc >>> FRAC_BITS;
        return acc[RESULT_W-1:0];
    endfunction

    function automatic void predict_sample(t_in_req r);
        int       nin, nout, ksz, pad, lag, ch, n;
        t_out_req e;
        nin  = clamp_cnt(reg_in, NIN_MAX);
        nout = clamp_cnt(reg_out, NOUT_MAX);
        ksz  = clamp_cnt(reg_k, KMAX);
        pad  = ksz / 2;
        lag  = ksz - 1 - pad;
        n    = 0;
        ch   = (ch_cnt >= nin) ? nin - 1 : ch_cnt;
        window[head*NIN_MAX+ch] = r.value;
        if (ch + 1 < nin && !r.last_sample) begin
            ch_cnt = ch + 1;
            return;
        end
        // zero-fill channels skipped by an early end
        for (int c = ch + 1; c < nin; c++) window[head*NIN_MAX+c] = '0;
        ch_cnt = 0;
        if (filled < KMAX) filled++;
        for (int b = lag; b >= 0; b--) begin
            if (!r.last_sample && b != lag) break;
            if (b >= filled) continue;
            for (int oc = 0; oc < nout; oc++) begin
                e.result      = conv_sum(oc, b, nin, ksz, pad);
                e.out_channel = oc[3:0];
                e.position    = pos_cnt - POS_W'(b);
                e.last_result = 1'b0;
                sums_q.push_back(e);
                n++;
            end
        end
        if (n > 0) sums_q[$].last_result = 1'b1;
        if (r.last_sample) begin
            clear_seq();
        end else begin
            pos_cnt = pos_cnt + 1'b1;
            head    = (head + 1) % KMAX;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_req e;
        if (!i_rst_n) begin
            clear_seq();
            reg_in  = 5'd1;
            reg_out = 5'd1;
            reg_k   = 3'd3;
            sums_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (sums_q.size() == 0) begin
                    $display("%0t: unexpected result actual=%p", $time, i_out_req);
                    o_fail_count++;
                end else begin
                    e = sums_q.pop_front();
                    if (e.result !== i_out_req.result ||
                        e.out_channel !== i_out_req.out_channel ||
                        e.position !== i_out_req.position ||
                        e.last_result !== i_out_req.last_result) begin
                        $display("%0t: mismatch expected=%p actual=%p", $time, e, i_out_req);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IN_CHANNELS: begin
                        reg_in = i_cfg_data;
                        clear_seq();
                    end
                    CFG_OUT_CHANNELS: begin
                        reg_out = i_cfg_data;
                        clear_seq();
                    end
                    CFG_KERNEL_SIZE: begin
                        reg_k = i_cfg_data[2:0];
                        clear_seq();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_req.mode == MODE_WEIGHT) begin
                    // taps past the store depth are dropped
                    if (i_in_req.weight_tap < KMAX)
                        coef_mem[(i_in_req.weight_out_channel*NIN_MAX +
                                  i_in_req.weight_in_channel)*KMAX +
                                 i_in_req.weight_tap] = i_in_req.value;
                end else begin
                    predict_sample(i_in_req);
                end
            end
        end
        o_pending = sums_q.size();
    end

endmodule

[tb/sv/multichannel_conv1d_same_pad_tb.sv]
// Top-level testbench for multichannel_conv1d_same_pad: drives requests and
// configuration, and gives the verdict. Depends on mcc_pkg and mcc_checker.
module multichannel_conv1d_same_pad_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mcc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 150;   // longer than one result's MAC pass
    localparam int STALL_LIMIT = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_req              i_in_req;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_req             o_out_req;

    int  fail_count, pending, idle_cycles, rx_stall;
    bit  tx_gaps_on, rx_gaps_on;
    int  cur_in;

    multichannel_conv1d_same_pad u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

    mcc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_req    (o_out_req),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp_cnt(int v, int m);
        if (v == 0) return 1;
        return (v > m) ? m : v;
    endfunction

    // Receiver: stall ready at random when enabled.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_stall = 0;
        end else if (rx_stall > 0) begin
            i_out_ready <= 1'b0;
            rx_stall--;
        end else begin
            i_out_ready <= 1'b1;
            if (rx_gaps_on) rx_stall = pick_gap();
        end
    end

    // Watchdog: abort when nothing is accepted for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles = 0;
        else if (++idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one request; hold valid and payload until accepted.
    task automatic send_req(t_in_req r);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_weight(int oc, int ic, int tap, logic [15:0] v);
        t_in_req r;
        r = t_in_req'($urandom);
        r.mode = MODE_WEIGHT;
        r.value = v;
        r.weight_out_channel = oc[3:0];
        r.weight_in_channel = ic[3:0];
        r.weight_tap = tap[2:0];
        send_req(r);
    endtask

    task automatic send_sample(logic [15:0] v, bit last);
        t_in_req r;
        r = t_in_req'($urandom);   // address fields are don't-care here
        r.mode = MODE_SAMPLE;
        r.value = v;
        r.last_sample = last;
        send_req(r);
    endtask

    // Write every weight that the given setting reads.
    task automatic fill_weights(int nin, int nout, int ksz);
        for (int oc = 0; oc < nout; oc++)
            for (int ic = 0; ic < nin; ic++)
                for (int k = 0; k < ksz; k++)
                    send_weight(oc, ic, k, 16'($urandom));
    endtask

    // Drop valid, wait for every result, then let the pipeline settle.
    task automatic drain();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(int nin, int nout, int ksz);
        drain();
        write_reg(CFG_IN_CHANNELS, nin[4:0]);
        write_reg(CFG_OUT_CHANNELS, nout[4:0]);
        write_reg(CFG_KERNEL_SIZE, ksz[4:0]);
        cur_in = clamp_cnt(nin, 16);
        fill_weights(cur_in, clamp_cnt(nout, 16), clamp_cnt(ksz, 7));
    endtask

    // One sequence of npos positions; an early end stops inside the final position.
    task automatic send_sequence(int npos, bit early, bit mix_weights);
        int stop_ch;
        stop_ch = early ? $urandom_range(0, cur_in - 1) : cur_in - 1;
        for (int p = 0; p < npos; p++)
            for (int c = 0; c < cur_in; c++) begin
                if (p == npos - 1 && c > stop_ch) break;
                // rewrite a weight between samples now and then
                if (mix_weights && $urandom_range(0, 19) == 0)
                    send_weight($urandom_range(0, 15), $urandom_range(0, 15),
                                $urandom_range(0, 6), 16'($urandom));
                send_sample(16'($urandom), p == npos - 1 && c == stop_ch);
            end
    endtask

    initial begin
        int cfg_in  [7] = '{3, 0, 1, 17, 1, 2, 1};
        int cfg_out [7] = '{2, 0, 20, 1, 1, 1, 1};
        int cfg_k   [7] = '{3, 0, 1, 1, 7, 6, 2};
        int nseq, npos;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        idle_cycles = 0;
        cur_in = 1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: extreme values, ignored tap, early end, one-position sequence.
        set_config(2, 2, 3);
        send_weight(0, 0, 1, 16'h7fff);
        send_weight(0, 1, 1, 16'h8000);
        send_weight(1, 0, 0, 16'h8000);
        send_weight(15, 15, 7, 16'h1234);     // tap beyond store: dropped
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h0001, 1'b1);
        send_sample(16'h8000, 1'b1);          // one position, early end on channel 0
        send_sample(16'hffff, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h7fff, 1'b0);          // position left open across the write below
        drain();
        write_reg(CFG_UNUSED, 5'h1f);         // no register there: sequence goes on
        send_sample(16'h4000, 1'b1);

        // Random: walk the settings, extremes included.
        for (int phase = 0; phase < 7; phase++) begin
            set_config(cfg_in[phase], cfg_out[phase], cfg_k[phase]);
            tx_gaps_on = (phase % 3) != 2;
            rx_gaps_on = (phase % 4) != 3;
            nseq = (cur_in >= 16) ? 1 : 2;
            for (int s = 0; s < nseq; s++) begin
                npos = (cur_in >= 16) ? 1 : $urandom_range(1, 8 / cur_in);
                send_sequence(npos, $urandom_range(0, 4) == 0, 1'b1);
                // hold the sender until the block has caught up
                if (phase == 1 && s == 0) drain();
            end
        end

        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
